[hw/rtl/mrc_pkg.sv]
// Package with shared types, constants and the CRC step for the Modbus RTU reply checker.
`default_nettype none

package mrc_pkg;

  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'hA001;
  localparam logic [7:0]  FUNC_READ_HOLD = 8'h03;
  localparam logic [7:0]  FUNC_EXC_FLAG  = 8'h80;
  localparam int          MIN_FRAME      = 5;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NO_RESP    = 3'd1,
    ST_TOO_SHORT  = 3'd2,
    ST_CRC_ERR    = 3'd3,
    ST_EXCEPTION  = 3'd4,
    ST_UNEXP_FUNC = 3'd5
  } status_t;

  typedef struct packed {
    logic        word_v;
    logic [6:0]  word_index;
    logic [15:0] word_value;
    logic        stat_v;
    status_t     status;
    logic [7:0]  exception_code;
    logic [15:0] register_count;
    logic [8:0]  frame_length;
  } mrc_bundle_t;

  function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/mrc_frame_core.sv]
// Frame state, CRC accumulation, data word extraction and status decision.
`default_nettype none

module mrc_frame_core
  import mrc_pkg::*;
#(
  parameter int MAX_FRAME = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        take,
  input  wire logic [7:0]  rx_byte,
  input  wire logic        byte_valid,
  input  wire logic        frame_end,
  output mrc_bundle_t      bnd
);

  localparam int CW = $clog2(MAX_FRAME + 1);

  logic [15:0]   crc, crc_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [7:0]    held0, held0_next;
  logic [7:0]    held1, held1_next;
  logic [7:0]    func_byte, func_byte_next;
  logic [7:0]    third_byte, third_byte_next;
  logic [15:0]   count_field, count_field_next;
  logic [7:0]    pend_high, pend_high_next;
  logic [6:0]    words_emitted, words_emitted_next;

  logic            accept_byte;
  logic [CW-1:0]   word_k;
  logic [CW+15:0]  word_k_ext;
  logic [CW+15:0]  count_ext;
  logic [CW+8:0]   len_ext;

  always_comb begin
    crc_next           = crc;
    cnt_next           = cnt;
    held0_next         = held0;
    held1_next         = held1;
    func_byte_next     = func_byte;
    third_byte_next    = third_byte;
    count_field_next   = count_field;
    pend_high_next     = pend_high;
    words_emitted_next = words_emitted;
    word_k             = (cnt - CW'(7)) >> 1;
    word_k_ext         = {16'd0, word_k};
    count_ext          = {{CW{1'b0}}, count_field};
    bnd                = '0;
    bnd.status         = ST_OK;
    accept_byte        = byte_valid && (cnt < CW'(MAX_FRAME));

    if (accept_byte) begin
      if (cnt >= CW'(2)) begin
        crc_next = crc16_feed(crc, held0);
        if (func_byte == FUNC_READ_HOLD && cnt >= CW'(6)) begin
          if (!cnt[0]) begin
            pend_high_next = held0;
          end else if (word_k_ext < count_ext) begin
            bnd.word_v         = 1'b1;
            bnd.word_index     = words_emitted;
            bnd.word_value     = {pend_high, held0};
            words_emitted_next = words_emitted + 7'd1;
          end
        end
      end
      if (cnt == CW'(1)) begin
        func_byte_next = rx_byte;
      end
      if (cnt == CW'(2)) begin
        third_byte_next         = rx_byte;
        count_field_next[15:8]  = rx_byte;
      end
      if (cnt == CW'(3)) begin
        count_field_next[7:0] = rx_byte;
      end
      held0_next = held1;
      held1_next = rx_byte;
      cnt_next   = cnt + CW'(1);
    end

    len_ext = {9'd0, cnt_next};

    if (frame_end) begin
      bnd.stat_v       = 1'b1;
      bnd.frame_length = len_ext[8:0];
      if (cnt_next == '0) begin
        bnd.status = ST_NO_RESP;
      end else if (cnt_next < CW'(MIN_FRAME)) begin
        bnd.status = ST_TOO_SHORT;
      end else if ({held1_next, held0_next} != crc_next) begin
        bnd.status = ST_CRC_ERR;
      end else if (func_byte_next == (FUNC_READ_HOLD | FUNC_EXC_FLAG)) begin
        bnd.status         = ST_EXCEPTION;
        bnd.exception_code = third_byte_next;
      end else if (func_byte_next == FUNC_READ_HOLD) begin
        bnd.status         = ST_OK;
        bnd.register_count = count_field_next;
      end else begin
        bnd.status = ST_UNEXP_FUNC;
      end
      crc_next           = CRC_INIT;
      cnt_next           = '0;
      held0_next         = '0;
      held1_next         = '0;
      func_byte_next     = '0;
      third_byte_next    = '0;
      count_field_next   = '0;
      pend_high_next     = '0;
      words_emitted_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc           <= CRC_INIT;
      cnt           <= '0;
      held0         <= '0;
      held1         <= '0;
      func_byte     <= '0;
      third_byte    <= '0;
      count_field   <= '0;
      pend_high     <= '0;
      words_emitted <= '0;
    end else if (take) begin
      crc           <= crc_next;
      cnt           <= cnt_next;
      held0         <= held0_next;
      held1         <= held1_next;
      func_byte     <= func_byte_next;
      third_byte    <= third_byte_next;
      count_field   <= count_field_next;
      pend_high     <= pend_high_next;
      words_emitted <= words_emitted_next;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(MAX_FRAME))
    else $error("Byte counter exceeds the frame limit.");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    (take && frame_end) |=> (cnt == '0 && crc == CRC_INIT && words_emitted == 7'd0))
    else $error("Frame state not restarted after frame end.");

  a_word_needs_func: assert property (@(posedge clk) disable iff (rst)
    bnd.word_v |-> (func_byte == FUNC_READ_HOLD && cnt[0] && cnt >= CW'(7)))
    else $error("Data word produced outside a read reply data field.");

endmodule

`default_nettype wire

[hw/rtl/mrc_out_stage.sv]
// Result register that delivers the data word and status of one item in order.
`default_nettype none

module mrc_out_stage
  import mrc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        load,
  input  wire mrc_bundle_t bnd,
  output logic             load_ready,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             kind,
  output logic [6:0]       word_index,
  output logic [15:0]      word_value,
  output logic [2:0]       status,
  output logic [7:0]       exception_code,
  output logic [15:0]      register_count,
  output logic [8:0]       frame_length,
  output logic             last
);

  mrc_bundle_t hold;
  logic        word_pending;
  logic        stat_pending;
  logic        emit;

  assign out_valid  = word_pending || stat_pending;
  assign emit       = out_valid && out_ready;
  assign load_ready = !out_valid || (out_ready && (word_pending ^ stat_pending));

  always_ff @(posedge clk) begin
    if (rst) begin
      word_pending <= 1'b0;
      stat_pending <= 1'b0;
    end else if (load) begin
      word_pending <= bnd.word_v;
      stat_pending <= bnd.stat_v;
    end else if (emit) begin
      if (word_pending) begin
        word_pending <= 1'b0;
      end else begin
        stat_pending <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hold <= bnd;
    end
  end

  assign kind           = !word_pending;
  assign word_index     = word_pending ? hold.word_index : 7'd0;
  assign word_value     = word_pending ? hold.word_value : 16'd0;
  assign status         = word_pending ? ST_OK : hold.status;
  assign exception_code = word_pending ? 8'd0 : hold.exception_code;
  assign register_count = word_pending ? 16'd0 : hold.register_count;
  assign frame_length   = word_pending ? 9'd0 : hold.frame_length;
  assign last           = word_pending ? !stat_pending : 1'b1;

endmodule

`default_nettype wire

[hw/rtl/modbus_rtu_response_checker_unit.sv]
// Top level of the Modbus RTU read holding registers reply checker.
//
//   Channel  Handshake             Word contents
//   input    in_valid / in_ready   rx_byte, byte_valid, frame_end
//   output   out_valid / out_ready kind, word_index, word_value, status,
//                                  exception_code, register_count,
//                                  frame_length, last
//
// One input word is taken per cycle unless a word with a result is waiting; the word
// is registered in the input register and its first result in the result register.
// A word that carries a data word and a frame status holds the result register until
// both results are taken, so a following word with a result waits for the status.
// Reset is synchronous and returns the frame state to an empty frame.
// A stalled output holds its word, and input stops once a word with a result is waiting.
`default_nettype none

module modbus_rtu_response_checker_unit
  import mrc_pkg::*;
#(
  parameter int MAX_FRAME = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  rx_byte,
  input  wire logic        byte_valid,
  input  wire logic        frame_end,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             kind,
  output logic [6:0]       word_index,
  output logic [15:0]      word_value,
  output logic [2:0]       status,
  output logic [7:0]       exception_code,
  output logic [15:0]      register_count,
  output logic [8:0]       frame_length,
  output logic             last
);

  logic        q_valid;
  logic [7:0]  q_byte;
  logic        q_byte_valid;
  logic        q_frame_end;
  logic        core_take;
  logic        load;
  logic        load_ready;
  logic        has_result;
  mrc_bundle_t bnd;

  assign has_result = bnd.word_v || bnd.stat_v;
  assign core_take  = q_valid && (!has_result || load_ready);
  assign load       = core_take && has_result;
  assign in_ready   = !q_valid || core_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      q_valid <= 1'b1;
    end else if (core_take) begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      q_byte       <= rx_byte;
      q_byte_valid <= byte_valid;
      q_frame_end  <= frame_end;
    end
  end

  mrc_frame_core #(
    .MAX_FRAME (MAX_FRAME)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .take       (core_take),
    .rx_byte    (q_byte),
    .byte_valid (q_byte_valid),
    .frame_end  (q_frame_end),
    .bnd        (bnd)
  );

  mrc_out_stage u_out (
    .clk            (clk),
    .rst            (rst),
    .load           (load),
    .bnd            (bnd),
    .load_ready     (load_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kind           (kind),
    .word_index     (word_index),
    .word_value     (word_value),
    .status         (status),
    .exception_code (exception_code),
    .register_count (register_count),
    .frame_length   (frame_length),
    .last           (last)
  );

endmodule

`default_nettype wire

[verif/modbus_rtu_response_checker_unit_tb.sv]
// Self-checking testbench for the Modbus RTU reply checker: random and directed frames.
`default_nettype none

module modbus_rtu_response_checker_unit_tb
  import mrc_pkg::*;
();

  localparam int FRAME_CAP = 256;
  localparam int ITEM_GOAL = 1850;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [7:0] b;
    logic       bv;
    logic       fe;
    bit         hold;
    int         ph;
  } stim_t;

  typedef struct packed {
    logic        kind;
    logic [6:0]  idx;
    logic [15:0] value;
    status_t     st;
    logic [7:0]  exc;
    logic [15:0] cnt;
    logic [8:0]  len;
    logic        last;
  } reply_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte = 8'h00;
  logic        byte_valid = 1'b0;
  logic        frame_end = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        kind;
  logic [6:0]  word_index;
  logic [15:0] word_value;
  logic [2:0]  status;
  logic [7:0]  exception_code;
  logic [15:0] register_count;
  logic [8:0]  frame_length;
  logic        last;

  stim_t      pending_words[$];
  reply_t     expected_replies[$];
  logic [7:0] frame_buf[$];
  int         n_items = 0;
  int         fault_cnt = 0;
  int         rcv_phase = 0;

  logic [15:0] crc_acc;
  int unsigned frame_cnt;
  logic [7:0]  held[2];
  logic [7:0]  func_code;
  logic [7:0]  third;
  logic [15:0] count_fld;
  logic [7:0]  hi_byte;
  logic [6:0]  word_cnt;

  modbus_rtu_response_checker_unit #(.MAX_FRAME(FRAME_CAP)) u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .rx_byte(rx_byte), .byte_valid(byte_valid), .frame_end(frame_end),
    .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .word_index(word_index), .word_value(word_value),
    .status(status), .exception_code(exception_code),
    .register_count(register_count), .frame_length(frame_length),
    .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] d);
    logic [15:0] a;
    logic        fb;
    int          i;
    a = acc;
    for (i = 0; i < 8; i++) begin
      fb = a[0] ^ d[i];
      a = a >> 1;
      if (fb) a = a ^ CRC_POLY;
    end
    return a;
  endfunction

  task automatic clear_frame();
    crc_acc = CRC_INIT;
    frame_cnt = 0;
    held[0] = 8'h00;
    held[1] = 8'h00;
    func_code = 8'h00;
    third = 8'h00;
    count_fld = 16'h0000;
    hi_byte = 8'h00;
    word_cnt = 7'd0;
  endtask

  task automatic predict_reply(input logic [7:0] b, input logic bv, input logic fe);
    reply_t      r[2];
    int          n;
    int          i;
    int unsigned pos;
    int unsigned q;
    logic [7:0]  c;
    n = 0;
    if (bv && frame_cnt < FRAME_CAP) begin
      pos = frame_cnt;
      if (pos >= 2) begin
        q = pos - 2;
        c = held[0];
        crc_acc = crc_step(crc_acc, c);
        if (func_code == FUNC_READ_HOLD && q >= 4) begin
          if (q % 2 == 0) begin
            hi_byte = c;
          end else if ((q - 5) / 2 < count_fld) begin
            r[n] = '0;
            r[n].idx = word_cnt;
            r[n].value = {hi_byte, c};
            r[n].st = ST_OK;
            n++;
            word_cnt = word_cnt + 7'd1;
          end
        end
      end
      if (pos == 1) func_code = b;
      if (pos == 2) begin
        third = b;
        count_fld[15:8] = b;
      end
      if (pos == 3) count_fld[7:0] = b;
      held[0] = held[1];
      held[1] = b;
      frame_cnt = pos + 1;
    end
    if (fe) begin
      r[n] = '0;
      r[n].kind = 1'b1;
      r[n].len = frame_cnt[8:0];
      if (frame_cnt == 0) begin
        r[n].st = ST_NO_RESP;
      end else if (frame_cnt < MIN_FRAME) begin
        r[n].st = ST_TOO_SHORT;
      end else if ({held[1], held[0]} != crc_acc) begin
        r[n].st = ST_CRC_ERR;
      end else if (func_code == (FUNC_READ_HOLD | FUNC_EXC_FLAG)) begin
        r[n].st = ST_EXCEPTION;
        r[n].exc = third;
      end else if (func_code == FUNC_READ_HOLD) begin
        r[n].st = ST_OK;
        r[n].cnt = count_fld;
      end else begin
        r[n].st = ST_UNEXP_FUNC;
      end
      n++;
      clear_frame();
    end
    if (n > 0) r[n-1].last = 1'b1;
    for (i = 0; i < n; i++) expected_replies = {expected_replies, r[i]};
  endtask

  task automatic push_item(input logic [7:0] b, input logic bv, input logic fe);
    stim_t s;
    s.b = b;
    s.bv = bv;
    s.fe = fe;
    s.hold = 1'b0;
    s.ph = (n_items < ITEM_GOAL / 3) ? 0 : (n_items < 2 * ITEM_GOAL / 3) ? 1 : 2;
    pending_words = {pending_words, s};
    if (bv || fe) n_items++;
  endtask

  task automatic push_hold();
    stim_t s;
    s = '{b: 8'h00, bv: 1'b0, fe: 1'b0, hold: 1'b1, ph: 0};
    pending_words = {pending_words, s};
  endtask

  task automatic append_crc();
    logic [15:0] acc;
    int          i;
    acc = CRC_INIT;
    for (i = 0; i < frame_buf.size(); i++) acc = crc_step(acc, frame_buf[i]);
    frame_buf = {frame_buf, acc[7:0]};
    frame_buf = {frame_buf, acc[15:8]};
  endtask

  task automatic corrupt_frame();
    int k;
    k = $urandom_range(0, frame_buf.size() - 1);
    frame_buf[k] = frame_buf[k] ^ (8'h01 << $urandom_range(0, 7));
  endtask

  task automatic build_read_reply(input logic [7:0] addr, input int nwords,
                                  input logic [15:0] cnt);
    logic [15:0] w;
    int          i;
    frame_buf = {};
    frame_buf = {frame_buf, addr};
    frame_buf = {frame_buf, FUNC_READ_HOLD};
    frame_buf = {frame_buf, cnt[15:8]};
    frame_buf = {frame_buf, cnt[7:0]};
    for (i = 0; i < nwords; i++) begin
      case ($urandom_range(0, 5))
        0: w = 16'h0000;
        1: w = 16'hFFFF;
        default: w = 16'($urandom_range(0, 65535));
      endcase
      frame_buf = {frame_buf, w[15:8]};
      frame_buf = {frame_buf, w[7:0]};
    end
    append_crc();
  endtask

  task automatic emit_frame(input bit sep_end);
    int i;
    for (i = 0; i < frame_buf.size(); i++) begin
      if ($urandom_range(0, 99) < 6) push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      push_item(frame_buf[i], 1'b1, !sep_end && i == frame_buf.size() - 1);
    end
    if (sep_end || frame_buf.size() == 0) push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  task automatic flag_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
      fault_cnt++;
    end
  endtask

  function automatic int sender_idle(input int ph);
    return (ph == 0) ? 30 : (ph == 1) ? 82 : 0;
  endfunction

  function automatic int receiver_idle(input int ph);
    return (ph == 0) ? 82 : (ph == 1) ? 30 : 0;
  endfunction

  always @(posedge clk) begin : driver
    stim_t nxt;
    bit    busy;
    bit    present;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      busy = in_valid;
      if (in_valid && in_ready) begin
        predict_reply(rx_byte, byte_valid, frame_end);
        busy = 1'b0;
      end
      if (!busy) begin
        present = 1'b0;
        while (pending_words.size() > 0 && pending_words[0].hold &&
               expected_replies.size() == 0) begin
          void'(pending_words.pop_front());
        end
        if (pending_words.size() > 0 && !pending_words[0].hold &&
            $urandom_range(0, 99) >= sender_idle(pending_words[0].ph)) begin
          nxt = pending_words.pop_front();
          rx_byte <= nxt.b;
          byte_valid <= nxt.bv;
          frame_end <= nxt.fe;
          rcv_phase = nxt.ph;
          present = 1'b1;
        end
        in_valid <= present;
      end
    end
  end

  always @(posedge clk) begin : monitor
    reply_t e;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_replies.size() == 0) begin
          $display("%0t: result with none expected, kind %0b status %0d value %0h",
                   $time, kind, status, word_value);
          fault_cnt++;
        end else begin
          e = expected_replies.pop_front();
          flag_field("kind", 32'(e.kind), 32'(kind));
          flag_field("word_index", 32'(e.idx), 32'(word_index));
          flag_field("word_value", 32'(e.value), 32'(word_value));
          flag_field("status", 32'(e.st), 32'(status));
          flag_field("exception_code", 32'(e.exc), 32'(exception_code));
          flag_field("register_count", 32'(e.cnt), 32'(register_count));
          flag_field("frame_length", 32'(e.len), 32'(frame_length));
          flag_field("last", 32'(e.last), 32'(last));
        end
      end
      out_ready <= ($urandom_range(0, 99) >= receiver_idle(rcv_phase));
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int          pick;
    int          nw;
    int          i;
    int          next_hold;
    bit          sep;
    bit          big_a;
    bit          big_b;
    logic [7:0]  addr;
    logic [7:0]  fc;
    logic [15:0] cnt;
    clear_frame();

    push_item(8'h00, 1'b0, 1'b1);
    push_item(8'hFF, 1'b1, 1'b1);
    // A five-byte read reply whose count low byte is the first CRC byte.
    frame_buf = '{8'hFF, FUNC_READ_HOLD, 8'hFF};
    append_crc();
    emit_frame(1'b0);
    frame_buf = '{8'h01, FUNC_READ_HOLD | FUNC_EXC_FLAG, 8'h02};
    append_crc();
    emit_frame(1'b0);
    frame_buf = '{8'h00, FUNC_READ_HOLD, 8'h00, 8'h01, 8'hFF, 8'hFF};
    append_crc();
    emit_frame(1'b0);
    frame_buf = '{8'h11, 8'h04, 8'h00};
    append_crc();
    emit_frame(1'b0);
    frame_buf = '{8'h01, FUNC_READ_HOLD | FUNC_EXC_FLAG, 8'h01};
    append_crc();
    frame_buf[4] = frame_buf[4] ^ 8'h80;
    emit_frame(1'b1);
    push_hold();

    next_hold = n_items + 350;
    big_a = 1'b0;
    big_b = 1'b0;
    while (n_items < ITEM_GOAL) begin
      if (n_items >= next_hold) begin
        push_hold();
        next_hold += 350;
      end
      addr = 8'($urandom_range(0, 255));
      sep = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      if (!big_a && n_items >= 200) begin
        // Full-size reply followed by bytes beyond the frame limit.
        big_a = 1'b1;
        build_read_reply(addr, 125, 16'd125);
        for (i = 0; i < 4; i++) frame_buf = {frame_buf, 8'($urandom_range(0, 255))};
        emit_frame(sep);
      end else if (!big_b && n_items >= 1300) begin
        big_b = 1'b1;
        frame_buf = {};
        for (i = 0; i < 258; i++) frame_buf = {frame_buf, 8'($urandom_range(0, 255))};
        frame_buf[1] = FUNC_READ_HOLD;
        frame_buf[2] = 8'hFF;
        frame_buf[3] = 8'hFF;
        emit_frame(sep);
      end else if (pick < 58) begin
        nw = $urandom_range(0, 6);
        case ($urandom_range(0, 9))
          6, 7: cnt = 16'(nw + $urandom_range(1, 3));
          8: cnt = 16'($urandom_range(0, nw));
          9: cnt = 16'($urandom_range(0, 65535));
          default: cnt = 16'(nw);
        endcase
        build_read_reply(addr, nw, cnt);
        if ($urandom_range(0, 9) == 0) corrupt_frame();
        emit_frame(sep);
      end else if (pick < 68) begin
        frame_buf = '{addr, FUNC_READ_HOLD | FUNC_EXC_FLAG, 8'($urandom_range(0, 255))};
        if ($urandom_range(0, 4) == 0) begin
          nw = $urandom_range(1, 3);
          for (i = 0; i < nw; i++) frame_buf = {frame_buf, 8'($urandom_range(0, 255))};
        end
        append_crc();
        if ($urandom_range(0, 9) == 0) corrupt_frame();
        emit_frame(sep);
      end else if (pick < 76) begin
        fc = 8'($urandom_range(0, 255));
        if (fc == FUNC_READ_HOLD || fc == (FUNC_READ_HOLD | FUNC_EXC_FLAG)) fc = fc ^ 8'h40;
        frame_buf = '{addr, fc};
        nw = $urandom_range(1, 8);
        for (i = 0; i < nw; i++) frame_buf = {frame_buf, 8'($urandom_range(0, 255))};
        append_crc();
        emit_frame(sep);
      end else if (pick < 84) begin
        frame_buf = {};
        nw = $urandom_range(1, 4);
        for (i = 0; i < nw; i++) frame_buf = {frame_buf, 8'($urandom_range(0, 255))};
        if (nw > 1 && $urandom_range(0, 1)) frame_buf[1] = FUNC_READ_HOLD;
        emit_frame(sep);
      end else if (pick < 92) begin
        frame_buf = {};
        nw = $urandom_range(0, 12);
        for (i = 0; i < nw; i++) frame_buf = {frame_buf, 8'($urandom_range(0, 255))};
        if (nw > 1 && $urandom_range(0, 1)) frame_buf[1] = FUNC_READ_HOLD;
        emit_frame(sep);
      end else begin
        build_read_reply(addr, $urandom_range(1, 5), 16'($urandom_range(0, 6)));
        nw = $urandom_range(1, 3);
        for (i = 0; i < nw; i++) void'(frame_buf.pop_back());
        emit_frame(sep);
      end
      if ($urandom_range(0, 9) == 0) push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk);
    while (pending_words.size() != 0 || in_valid || expected_replies.size() != 0);
    repeat (10) @(posedge clk);
    if (fault_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
hw/rtl/mrc_pkg.sv
hw/rtl/mrc_frame_core.sv
hw/rtl/mrc_out_stage.sv
hw/rtl/modbus_rtu_response_checker_unit.sv
verif/modbus_rtu_response_checker_unit_tb.sv
